FILE: hw/rtl/pcm_frame_deframer_macros.svh
// ---------------------------------------------------------------------------
// pcm frame deframer assertion macros
// property wrappers for the deframer rtl
// ---------------------------------------------------------------------------
`ifndef PCM_FRAME_DEFRAMER_MACROS_SVH
`define PCM_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define PCMDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcmdf assertion failed");

// next-cycle implication
`define PCMDF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcmdf assertion failed");

`endif

FILE: hw/rtl/pcmdf_pkg.sv
// ---------------------------------------------------------------------------
// pcmdf_pkg
// types, constants and expansion functions of the pcm frame deframer
// ---------------------------------------------------------------------------
package pcmdf_pkg;

  localparam int FRAME_BYTES = 56;
  localparam int SAMPLE_W    = 17;

  localparam logic [5:0] FILL_FULL      = 6'd56;
  localparam logic [5:0] SAMPLES_NARROW = 6'd50;
  localparam logic [5:0] SAMPLES_WIDE   = 6'd25;

  localparam logic [7:0] SYNC_HEAD   = 8'd100;
  localparam logic [7:0] SYNC_TAIL   = 8'd101;
  localparam logic [7:0] TYPE_NARROW = 8'd88;
  localparam logic [7:0] TYPE_WIDE   = 8'd89;

  localparam logic [4:0] WIDTH_RESET = 5'd12;
  localparam logic [4:0] WIDTH_BYTE  = 5'd8;
  localparam logic [4:0] WIDTH_WRAP  = 5'd17;

  typedef enum logic [1:0] {
    REG_SAMPLE_WIDTH = 2'd0,
    REG_COMPANDING   = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMP_NONE  = 2'd0,
    CMP_MULAW = 2'd1,
    CMP_ALAW  = 2'd2
  } cmp_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_EMIT  = 2'd2
  } state_t;

  typedef struct packed {
    logic shift_in;
    logic load;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic wide;
    logic out_stall;
  } sts_t;

  // mu-law expansion divided by 16, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] mulaw_div16(input logic [7:0] code);
    logic [7:0]  u;
    logic [15:0] t;
    logic [15:0] mag;
    logic [16:0] q;
    u   = ~code;
    t   = ({12'd0, u[3:0]} << 3) + 16'h0084;
    t   = t << u[6:4];
    mag = t - 16'h0084;
    q   = {5'd0, mag[15:4]};
    return u[7] ? -q : q;
  endfunction

  // a-law expansion divided by 16, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] alaw_div16(input logic [7:0] code);
    logic [7:0]  a;
    logic [15:0] t;
    logic [16:0] q;
    a = code ^ 8'h55;
    t = {8'd0, a[3:0], 4'd0};
    if (a[6:4] == 3'd0) begin
      t = t + 16'd8;
    end else begin
      t = (t + 16'h0108) << (a[6:4] - 3'd1);
    end
    q = {5'd0, t[15:4]};
    return a[7] ? q : -q;
  endfunction

endpackage

FILE: hw/rtl/pcmdf_ctrl.sv
// ---------------------------------------------------------------------------
// pcmdf_ctrl
// sequencer: byte intake, frame test and sample emission
// ---------------------------------------------------------------------------
`include "pcm_frame_deframer_macros.svh"

module pcmdf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  pcmdf_pkg::sts_t sts,
  output pcmdf_pkg::cmd_t cmd
);
  import pcmdf_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] count_r, count_nxt;
  logic [5:0] total;
  logic       is_last;

  assign total   = sts.wide ? SAMPLES_WIDE : SAMPLES_NARROW;
  assign is_last = (count_r == total - 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        count_nxt = '0;
        state_nxt = sts.frame_ok ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!sts.out_stall) begin
          count_nxt = count_r + 6'd1;
          if (is_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.shift_in = in_tvalid;
      end
      ST_CHECK: begin
      end
      ST_EMIT: begin
        cmd.load = !sts.out_stall;
        cmd.last = is_last;
      end
      default: begin
      end
    endcase
  end

  `PCMDF_ASSERT_IMP(a_load_in_emit, cmd.load, state_r == ST_EMIT)
  `PCMDF_ASSERT_NXT(a_byte_then_check, cmd.shift_in, state_r == ST_CHECK)
  `PCMDF_ASSERT_IMP(a_count_bound, state_r == ST_EMIT, count_r < SAMPLES_NARROW)
  `PCMDF_ASSERT_NXT(a_last_to_idle, cmd.load && cmd.last, state_r == ST_IDLE)

endmodule

FILE: hw/rtl/pcmdf_datapath.sv
// ---------------------------------------------------------------------------
// pcmdf_datapath
// byte window, running checksum, config registers and sample output stage
// ---------------------------------------------------------------------------
module pcmdf_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 rx_byte,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [4:0]                 cfg_data,
  input  pcmdf_pkg::cmd_t            cmd,
  output pcmdf_pkg::sts_t            sts,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic signed [16:0]         sample_value,
  output logic                       frame_last
);
  import pcmdf_pkg::*;

  logic [7:0]  win_r [FRAME_BYTES];
  logic [7:0]  win_nxt [FRAME_BYTES];
  logic [15:0] sum_r, sum_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [4:0]  width_r;
  logic [1:0]  mode_r;
  logic        wide;
  logic [16:0] offset;
  logic signed [16:0] smp;
  logic        outv_r, outv_nxt;
  logic signed [16:0] smp_r;
  logic        last_r;

  assign wide = (width_r > WIDTH_BYTE);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      mode_r  <= CMP_NONE;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SAMPLE_WIDTH: width_r <= cfg_data;
        REG_COMPANDING:   mode_r  <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // window: newest byte at the top, emission shifts toward the bottom, the final sample clears it
  always_comb begin
    for (int k = 0; k < FRAME_BYTES; k++) begin
      win_nxt[k] = win_r[k];
    end
    sum_nxt  = sum_r;
    fill_nxt = fill_r;
    if (cmd.load && cmd.last) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        win_nxt[k] = '0;
      end
      sum_nxt  = '0;
      fill_nxt = '0;
    end else if (cmd.load) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        if (wide) begin
          win_nxt[k] = (k < FRAME_BYTES - 2) ? win_r[(k + 2) % FRAME_BYTES] : 8'd0;
        end else begin
          win_nxt[k] = (k < FRAME_BYTES - 1) ? win_r[(k + 1) % FRAME_BYTES] : 8'd0;
        end
      end
    end else if (cmd.shift_in) begin
      for (int k = 0; k < FRAME_BYTES - 1; k++) begin
        win_nxt[k] = win_r[k + 1];
      end
      win_nxt[FRAME_BYTES-1] = rx_byte;
      sum_nxt = sum_r + {8'd0, win_r[53]} - {8'd0, win_r[3]};
      if (fill_r != FILL_FULL) fill_nxt = fill_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        win_r[k] <= '0;
      end
      sum_r  <= '0;
      fill_r <= '0;
    end else begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        win_r[k] <= win_nxt[k];
      end
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
    end
  end

  // frame test on the current window
  assign sts.frame_ok = (fill_r == FILL_FULL) &&
                        (win_r[0] == SYNC_HEAD) &&
                        (win_r[FRAME_BYTES-1] == SYNC_TAIL) &&
                        (win_r[1] == (wide ? TYPE_WIDE : TYPE_NARROW)) &&
                        (win_r[2] == 8'd0) &&
                        (sum_r == {win_r[53], win_r[54]});
  assign sts.wide      = wide;
  assign sts.out_stall = outv_r && !out_tready;

  // sample decode from the head of the payload
  always_comb begin
    if (width_r == 5'd0 || width_r > WIDTH_WRAP) begin
      offset = '0;
    end else begin
      offset = 17'd1 << (width_r - 5'd1);
    end
    if (wide) begin
      smp = $signed({win_r[3][7], win_r[3], win_r[4]} - offset);
    end else begin
      case (cmp_mode_t'(mode_r))
        CMP_MULAW: smp = mulaw_div16(win_r[3]);
        CMP_ALAW:  smp = alaw_div16(win_r[3]);
        default:   smp = $signed({9'd0, win_r[3]} - offset);
      endcase
    end
  end

  // output register
  always_comb begin
    outv_nxt = outv_r;
    if (cmd.load) begin
      outv_nxt = 1'b1;
    end else if (out_tready) begin
      outv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else begin
      outv_r <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r  <= smp;
      last_r <= cmd.last;
    end
  end

  assign out_tvalid   = outv_r;
  assign sample_value = smp_r;
  assign frame_last   = last_r;

endmodule

FILE: hw/rtl/pcm_frame_deframer.sv
// ---------------------------------------------------------------------------
// pcm_frame_deframer
// finds 56-byte pcm frames in a byte stream and emits their decoded samples
// ---------------------------------------------------------------------------
// usage
//   in_*  : one received byte per request, tdata[7:0]
//   out_* : one decoded sample per request, tdata[16:0] signed, tlast marks
//           the final sample of a frame
//   cfg_* : register writes (index 0 sample width, index 1 companding mode),
//           always ready, write only while the block is idle
// sequence
//   each byte goes through intake, then the frame test on the window, which
//   checks the checksum kept as a running sum; an accepted frame then emits
//   50 samples (25 for wide samples) at one per cycle unless out_tready
//   stalls; the emit state loads each sample into the output register
// reset
//   rst_n clears the window, fill count and checksum and loads the register
//   defaults (width 12, no companding); no clearing pass is needed
// stall
//   a stalled out_tready holds the current sample and pauses emission;
//   no byte is taken while a frame is being emitted
// ---------------------------------------------------------------------------
module pcm_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] sample_value, [23:17] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import pcmdf_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic signed [16:0] sample_value;

  assign cfg_ready = 1'b1;

  pcmdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcmdf_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_byte      (in_tdata),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .sample_value (sample_value),
    .frame_last   (out_tlast)
  );

  assign out_tdata = {7'd0, sample_value};

endmodule
